// ----- hdl/stas_pkg.sv -----
// Shared types and constants of the sprite tile animation stepper.
// Holds the configuration record, mode and register codes, and the divider records.
// No dependencies.
package stas_pkg;

  localparam int EDGE_PAD_DEF = 0;
  localparam int GAP_DEF      = 0;

  // Divider operand width; covers the largest tile pitch and sheet size plus spacing.
  localparam int DIV_W     = 17;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_ONCE_FWD  = 3'd1;
  localparam logic [2:0] MODE_ONCE_BACK = 3'd2;
  localparam logic [2:0] MODE_LOOP_FWD  = 3'd3;
  localparam logic [2:0] MODE_LOOP_BACK = 3'd4;
  localparam logic [2:0] MODE_PINGPONG  = 3'd5;

  localparam logic [2:0] CFG_MODE       = 3'd0;
  localparam logic [2:0] CFG_FIRST_TILE = 3'd1;
  localparam logic [2:0] CFG_LAST_TILE  = 3'd2;
  localparam logic [2:0] CFG_PERIOD     = 3'd3;
  localparam logic [2:0] CFG_TILE_W     = 3'd4;
  localparam logic [2:0] CFG_TILE_H     = 3'd5;
  localparam logic [2:0] CFG_TEX_W      = 3'd6;
  localparam logic [2:0] CFG_TEX_H      = 3'd7;

  typedef struct packed {
    logic [2:0]  playback_mode;
    logic [15:0] first_tile;
    logic [15:0] last_tile;
    logic [31:0] frame_period;
    logic [15:0] tile_width;
    logic [15:0] tile_height;
    logic [15:0] sheet_width;
    logic [15:0] sheet_height;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             idle;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- hdl/stas_divider.sv -----
// Shared restoring divider of the stepper, one quotient bit per cycle.
// Depends on stas_pkg for the operand width and the request and response records.
module stas_divider
  import stas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     divisor_r;
  logic [DIV_W:0]       trial;
  logic [DIV_W+1:0]     diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_r};
  assign fits  = ~diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r     <= DIV_CNT_W'(DIV_W);
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.idle      = (cnt_r == '0);
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- hdl/stas_step.sv -----
// Tile advance logic of the stepper: one frame step under the playback mode.
// Depends on stas_pkg for the configuration record and mode codes.
module stas_step
  import stas_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [15:0] tile,
  input  logic        reversed,
  input  logic [33:0] num_tiles,
  output logic [15:0] tile_nxt,
  output logic        rev_nxt
);

  logic        fwd;
  logic        back;
  logic        jump;
  logic [16:0] cand;
  logic [15:0] count_m1;
  logic [15:0] low_val;
  logic        wrap_low;
  logic        out_of_range;
  logic        at_end;

  assign at_end = (tile == cfg.last_tile);

  always_comb begin
    fwd  = 1'b0;
    back = 1'b0;
    jump = 1'b0;
    case (cfg.playback_mode)
      MODE_ONCE_FWD:  fwd  = ~at_end;
      MODE_ONCE_BACK: back = ~at_end;
      MODE_LOOP_FWD: begin
        jump = at_end;
        fwd  = ~at_end;
      end
      MODE_LOOP_BACK: begin
        jump = at_end;
        back = ~at_end;
      end
      MODE_PINGPONG: begin
        fwd  = ~reversed;
        back = reversed;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (jump) begin
      cand = {1'b0, cfg.first_tile};
    end else if (fwd) begin
      cand = {1'b0, tile} + 17'd1;
    end else if (back) begin
      cand = {1'b0, tile} - 17'd1;
    end else begin
      cand = {1'b0, tile};
    end
  end

  assign count_m1     = num_tiles[15:0] - 16'd1;
  assign low_val      = (num_tiles == '0 || num_tiles > 34'd65536) ? 16'hFFFF : count_m1;
  assign wrap_low     = back && (tile == '0);
  assign out_of_range = ({17'b0, cand} >= num_tiles) || cand[16];

  always_comb begin
    if (wrap_low) begin
      tile_nxt = low_val;
    end else if (out_of_range) begin
      tile_nxt = '0;
    end else begin
      tile_nxt = cand[15:0];
    end
  end

  assign rev_nxt = reversed ^ ((cfg.playback_mode == MODE_PINGPONG) &&
                               (tile_nxt == cfg.first_tile || tile_nxt == cfg.last_tile));

endmodule

// ----- hdl/sprite_tile_animation_stepper.sv -----
// Sprite tile animation stepper: top level with sequencer, state and configuration.
// Depends on stas_pkg, stas_divider and stas_step.
// A result follows the input transfer after three passes of the shared divider (tiles per
// row, tiles per column, column and row) plus timer steps.
// No item is taken while one is in work; in_tready is high only when idle.
// Reset (synchronous, active low) clears configuration and animation state.
module sprite_tile_animation_stepper
  import stas_pkg::*;
#(
  parameter int EDGE_PAD = EDGE_PAD_DEF,
  parameter int GAP      = GAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // elapsed_ticks
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  // tile_index, tile_column, tile_row, is_playing, is_reversed, done_res, zero fill
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [DIV_W-1:0] PAD = DIV_W'(2 * EDGE_PAD + GAP);
  localparam logic [DIV_W-1:0] SPC = DIV_W'(GAP);

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_ROW_WAIT, S_COL, S_COL_WAIT, S_MUL,
    S_TIMER, S_CMP, S_ADV, S_POS, S_POS_WAIT, S_OUT
  } state_t;

  state_t      state_r;
  cfg_t        cfg_r;
  logic        action_r;
  logic [15:0] elapsed_r;
  logic [15:0] tile_r;
  logic [31:0] timer_r;
  logic        playing_r;
  logic        rev_r;
  logic        done_r;
  logic [DIV_W-1:0] per_row_r;
  logic [DIV_W-1:0] per_col_r;
  logic [33:0] count_r;
  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [DIV_W-1:0] pitch_w;
  logic [DIV_W-1:0] pitch_h;
  logic [32:0] sum;
  logic [32:0] diff;
  logic        stop;
  logic        play_now;
  logic [15:0] adv_tile;
  logic        adv_rev;
  logic [15:0] col_val;
  logic [15:0] row_val;

  stas_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  stas_step u_step (
    .cfg       (cfg_r),
    .tile      (tile_r),
    .reversed  (rev_r),
    .num_tiles (count_r),
    .tile_nxt  (adv_tile),
    .rev_nxt   (adv_rev)
  );

  assign pitch_w  = PAD + {1'b0, cfg_r.tile_width};
  assign pitch_h  = PAD + {1'b0, cfg_r.tile_height};
  assign sum      = {1'b0, timer_r} + {17'b0, elapsed_r};
  assign diff     = {1'b0, timer_r} - {1'b0, cfg_r.frame_period};
  assign stop     = (cfg_r.playback_mode == MODE_ONCE_FWD ||
                     cfg_r.playback_mode == MODE_ONCE_BACK) && (tile_r == cfg_r.last_tile);
  assign play_now = playing_r & ~stop;
  assign col_val  = (per_row_r == '0) ? 16'h0000 : div_rsp.remainder[15:0];
  assign row_val  = (per_row_r == '0) ? 16'h0000 : div_rsp.quotient[15:0];

  always_comb begin
    div_req = '0;
    case (state_r)
      S_ROW: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, cfg_r.sheet_width} + SPC;
        div_req.divisor  = pitch_w;
      end
      S_COL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, cfg_r.sheet_height} + SPC;
        div_req.divisor  = pitch_h;
      end
      S_POS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, tile_r};
        div_req.divisor  = per_row_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= '0;
      tile_r       <= '0;
      timer_r      <= '0;
      playing_r    <= 1'b0;
      rev_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:       cfg_r.playback_mode <= cfg_wdata[2:0];
          CFG_FIRST_TILE: cfg_r.first_tile    <= cfg_wdata[15:0];
          CFG_LAST_TILE:  cfg_r.last_tile     <= cfg_wdata[15:0];
          CFG_PERIOD:     cfg_r.frame_period  <= cfg_wdata;
          CFG_TILE_W:     cfg_r.tile_width    <= cfg_wdata[15:0];
          CFG_TILE_H:     cfg_r.tile_height   <= cfg_wdata[15:0];
          CFG_TEX_W:      cfg_r.sheet_width   <= cfg_wdata[15:0];
          CFG_TEX_H:      cfg_r.sheet_height  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            action_r  <= in_tuser;
            elapsed_r <= in_tdata;
            state_r   <= S_ROW;
          end
        end
        S_ROW: state_r <= S_ROW_WAIT;
        S_ROW_WAIT: begin
          if (div_rsp.idle) begin
            per_row_r <= (pitch_w == '0) ? '0 : div_rsp.quotient;
            state_r   <= S_COL;
          end
        end
        S_COL: state_r <= S_COL_WAIT;
        S_COL_WAIT: begin
          if (div_rsp.idle) begin
            per_col_r <= (pitch_h == '0) ? '0 : div_rsp.quotient;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          count_r <= per_row_r * per_col_r;
          state_r <= S_TIMER;
        end
        S_TIMER: begin
          if (action_r) begin
            tile_r    <= cfg_r.first_tile;
            timer_r   <= '0;
            rev_r     <= 1'b0;
            playing_r <= (cfg_r.playback_mode != MODE_NONE);
            done_r    <= 1'b0;
            state_r   <= S_POS;
          end else begin
            done_r    <= stop & playing_r;
            playing_r <= play_now;
            if (play_now) begin
              timer_r <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              state_r <= S_CMP;
            end else begin
              state_r <= S_POS;
            end
          end
        end
        S_CMP: begin
          if (!diff[32]) begin
            timer_r <= diff[31:0];
            state_r <= S_ADV;
          end else begin
            state_r <= S_POS;
          end
        end
        S_ADV: begin
          tile_r  <= adv_tile;
          rev_r   <= adv_rev;
          state_r <= S_POS;
        end
        S_POS: state_r <= S_POS_WAIT;
        S_POS_WAIT: begin
          if (div_rsp.idle) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {5'b0, done_r, rev_r, playing_r, row_val, col_val, tile_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
